// ----- rtl/lsrw_pkg.sv -----
// Constants and codes for the lattice site record weigher.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package lsrw_pkg;

  // parser phases
  localparam logic [2:0] PH_SITE_FLAG   = 3'd0;
  localparam logic [2:0] PH_LINK_TYPE   = 3'd1;
  localparam logic [2:0] PH_PAY_CFG     = 3'd2;
  localparam logic [2:0] PH_PAY_LAST    = 3'd3;
  localparam logic [2:0] PH_NORMAL_FLAG = 3'd4;
  localparam logic [2:0] PH_NORMAL      = 3'd5;
  localparam logic [2:0] PH_DONE        = 3'd6;

  // site classes
  localparam logic [2:0] CL_FLUID       = 3'd0;
  localparam logic [2:0] CL_WALL        = 3'd1;
  localparam logic [2:0] CL_INLET       = 3'd2;
  localparam logic [2:0] CL_OUTLET      = 3'd3;
  localparam logic [2:0] CL_INLET_WALL  = 3'd4;
  localparam logic [2:0] CL_OUTLET_WALL = 3'd5;
  localparam logic [2:0] CL_CONFLICT    = 3'd6;

  // link type words
  localparam logic [31:0] LT_FLUID  = 32'd0;
  localparam logic [31:0] LT_WALL   = 32'd1;
  localparam logic [31:0] LT_INLET  = 32'd2;
  localparam logic [31:0] LT_OUTLET = 32'd3;

  // flag words
  localparam logic [31:0] FLAG_CLEAR = 32'd0;
  localparam logic [31:0] FLAG_SET   = 32'd1;

  // result status
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_LINK    = 2'd1;
  localparam logic [1:0] ST_CONFLICT    = 2'd2;
  localparam logic [1:0] ST_BAD_NORMAL  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_W_FLUID       = 3'd0;
  localparam logic [2:0] REG_W_WALL        = 3'd1;
  localparam logic [2:0] REG_W_INLET       = 3'd2;
  localparam logic [2:0] REG_W_OUTLET      = 3'd3;
  localparam logic [2:0] REG_W_INLET_WALL  = 3'd4;
  localparam logic [2:0] REG_W_OUTLET_WALL = 3'd5;
  localparam logic [2:0] REG_BLOCK_EDGE    = 3'd6;

  localparam logic [4:0] LINKS_PER_SITE = 5'd26;
  localparam logic [4:0] NORMAL_WORDS   = 5'd3;

  localparam logic [31:0] WEIGHT_RESET = 32'd1;
  localparam logic [4:0]  EDGE_RESET   = 5'd8;

endpackage

// ----- rtl/lattice_site_record_weigher_unit.sv -----
// Lattice site record weigher: walks the site records of a block word by word
// and emits the weighted site-class sum, or an error code. Uses lsrw_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: data_word; s_tuser: block_start
// m_*       out  m_tvalid/m_tready  m_tdata: block_weight; m_tuser: status
// cfg_*     in   cfg_we             cfg_index selects register, cfg_data value
//
// One item per cycle sustained unless the result register stalls; an item
// passes an input register and the parse step, and its result (if any) is
// loaded into the result register. The parse step is a phase decision,
// counter compares and one 32-bit add. Reset clears the parser and restores
// the default weights (1) and edge (8). A stalled result register holds the
// parse step; the input register then fills and s_tready drops.

module lattice_site_record_weigher_unit
  import lsrw_pkg::*;
#(
  parameter int MAX_EDGE = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_word
  input  logic        s_tuser,   // [0] block_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] block_weight
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int EW = $clog2(MAX_EDGE + 1);
  localparam int SW = $clog2(MAX_EDGE * MAX_EDGE * MAX_EDGE + 1);

  // configuration
  logic [31:0] w_fluid, w_wall, w_inlet, w_outlet, w_inlet_wall, w_outlet_wall;
  logic [4:0]  edge_cfg;
  logic [SW-1:0] site_limit;

  // input register
  logic        in_valid;
  logic [31:0] in_word;
  logic        in_start;

  // parser state
  logic [2:0]    phase, phase_next;
  logic [4:0]    link_cnt, link_cnt_next;
  logic [SW-1:0] site_cnt, site_cnt_next;
  logic [2:0]    site_class, site_class_next;
  logic [31:0]   block_sum, block_sum_next;
  logic          err_hold, err_hold_next;

  // result register
  logic        out_valid;
  logic [31:0] out_weight;
  logic [1:0]  out_status;

  logic        adv, step;
  logic        res_valid;
  logic [31:0] res_weight;
  logic [1:0]  res_status;

  logic [EW-1:0]   edge_clamped;
  logic [2*EW-1:0] edge_sq;
  logic [3*EW-1:0] edge_cube;

  assign adv      = !out_valid || m_tready;
  assign step     = in_valid && adv;
  assign s_tready = !in_valid || adv;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_weight;
  assign m_tuser  = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_fluid       <= WEIGHT_RESET;
      w_wall        <= WEIGHT_RESET;
      w_inlet       <= WEIGHT_RESET;
      w_outlet      <= WEIGHT_RESET;
      w_inlet_wall  <= WEIGHT_RESET;
      w_outlet_wall <= WEIGHT_RESET;
      edge_cfg      <= EDGE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_W_FLUID:       w_fluid       <= cfg_data;
        REG_W_WALL:        w_wall        <= cfg_data;
        REG_W_INLET:       w_inlet       <= cfg_data;
        REG_W_OUTLET:      w_outlet      <= cfg_data;
        REG_W_INLET_WALL:  w_inlet_wall  <= cfg_data;
        REG_W_OUTLET_WALL: w_outlet_wall <= cfg_data;
        REG_BLOCK_EDGE:    edge_cfg      <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sites per block, clamped edge cubed; registered, user writes config idle
  always_comb begin
    if (edge_cfg == 5'd0) begin
      edge_clamped = EW'(1);
    end else if (int'(edge_cfg) > MAX_EDGE) begin
      edge_clamped = EW'(MAX_EDGE);
    end else begin
      edge_clamped = EW'(edge_cfg);
    end
    edge_sq   = (2*EW)'(edge_clamped) * (2*EW)'(edge_clamped);
    edge_cube = (3*EW)'(edge_sq) * (3*EW)'(edge_clamped);
  end

  always_ff @(posedge clk) begin
    site_limit <= SW'(edge_cube);
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_word  <= s_tdata;
      in_start <= s_tuser;
    end
  end

  // parse step
  always_comb begin
    logic [2:0]    ph;
    logic [4:0]    lc;
    logic [SW-1:0] sc;
    logic [2:0]    cl;
    logic [31:0]   sm;
    logic          eh;
    logic          link_fin;
    logic          site_fin;
    logic [31:0]   cw;

    ph = phase;
    lc = link_cnt;
    sc = site_cnt;
    cl = site_class;
    sm = block_sum;
    eh = err_hold;
    link_fin = 1'b0;
    site_fin = 1'b0;
    res_valid  = 1'b0;
    res_weight = 32'd0;
    res_status = ST_OK;

    if (step) begin
      if (in_start) begin
        ph = PH_SITE_FLAG;
        lc = 5'd0;
        sc = '0;
        cl = CL_FLUID;
        sm = 32'd0;
        eh = 1'b0;
      end
      if (!eh && ph != PH_DONE) begin
        case (ph)
          PH_SITE_FLAG: begin
            if (in_word != FLAG_SET) begin
              site_fin = 1'b1;
            end else begin
              cl = CL_FLUID;
              lc = 5'd0;
              ph = PH_LINK_TYPE;
            end
          end
          PH_LINK_TYPE: begin
            case (in_word)
              LT_FLUID: link_fin = 1'b1;
              LT_WALL: begin
                case (cl)
                  CL_FLUID:  cl = CL_WALL;
                  CL_INLET:  cl = CL_INLET_WALL;
                  CL_OUTLET: cl = CL_OUTLET_WALL;
                  default: ;
                endcase
                ph = PH_PAY_LAST;
              end
              LT_INLET: begin
                case (cl)
                  CL_FLUID:       cl = CL_INLET;
                  CL_WALL:        cl = CL_INLET_WALL;
                  CL_OUTLET:      cl = CL_CONFLICT;
                  CL_OUTLET_WALL: cl = CL_CONFLICT;
                  default: ;
                endcase
                ph = PH_PAY_CFG;
              end
              LT_OUTLET: begin
                case (cl)
                  CL_FLUID:      cl = CL_OUTLET;
                  CL_WALL:       cl = CL_OUTLET_WALL;
                  CL_INLET:      cl = CL_CONFLICT;
                  CL_INLET_WALL: cl = CL_CONFLICT;
                  default: ;
                endcase
                ph = PH_PAY_CFG;
              end
              default: begin
                eh = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_BAD_LINK;
              end
            endcase
          end
          PH_PAY_CFG:  ph = PH_PAY_LAST;
          PH_PAY_LAST: link_fin = 1'b1;
          PH_NORMAL_FLAG: begin
            if (in_word == FLAG_CLEAR) begin
              site_fin = 1'b1;
            end else if (in_word == FLAG_SET) begin
              lc = 5'd0;
              ph = PH_NORMAL;
            end else begin
              eh = 1'b1;
              res_valid  = 1'b1;
              res_status = ST_BAD_NORMAL;
            end
          end
          PH_NORMAL: begin
            lc = lc + 5'd1;
            if (lc >= NORMAL_WORDS) begin
              site_fin = 1'b1;
            end
          end
          default: ph = PH_DONE;
        endcase
      end

      case (cl)
        CL_FLUID:       cw = w_fluid;
        CL_WALL:        cw = w_wall;
        CL_INLET:       cw = w_inlet;
        CL_OUTLET:      cw = w_outlet;
        CL_INLET_WALL:  cw = w_inlet_wall;
        CL_OUTLET_WALL: cw = w_outlet_wall;
        default:        cw = 32'd0;
      endcase

      // end of one link record: next link, or close the link list
      if (link_fin) begin
        lc = lc + 5'd1;
        if (lc < LINKS_PER_SITE) begin
          ph = PH_LINK_TYPE;
        end else if (cl == CL_CONFLICT) begin
          eh = 1'b1;
          res_valid  = 1'b1;
          res_status = ST_CONFLICT;
        end else begin
          sm = sm + cw;
          ph = PH_NORMAL_FLAG;
        end
      end

      // end of one site: last site of the block emits the sum
      if (site_fin) begin
        sc = sc + SW'(1);
        ph = PH_SITE_FLAG;
        if (sc >= site_limit) begin
          ph = PH_DONE;
          res_valid  = 1'b1;
          res_weight = sm;
          res_status = ST_OK;
        end
      end
    end else begin
      cw = 32'd0;
    end

    phase_next      = ph;
    link_cnt_next   = lc;
    site_cnt_next   = sc;
    site_class_next = cl;
    block_sum_next  = sm;
    err_hold_next   = eh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SITE_FLAG;
      link_cnt   <= 5'd0;
      site_cnt   <= '0;
      site_class <= CL_FLUID;
      block_sum  <= 32'd0;
      err_hold   <= 1'b0;
    end else begin
      phase      <= phase_next;
      link_cnt   <= link_cnt_next;
      site_cnt   <= site_cnt_next;
      site_class <= site_class_next;
      block_sum  <= block_sum_next;
      err_hold   <= err_hold_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_weight <= res_weight;
      out_status <= res_status;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero_weight: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 32'd0))
    else $error("error result with nonzero weight");

  a_link_cnt_range: assert property (@(posedge clk) disable iff (rst)
    link_cnt <= LINKS_PER_SITE)
    else $error("link counter past link count");

  a_held_silent: assert property (@(posedge clk) disable iff (rst)
    (step && !in_start && (err_hold || phase == PH_DONE)) |-> !res_valid)
    else $error("result from a held or finished block");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty result register");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=> ($stable(phase) && $stable(block_sum)))
    else $error("parser moved while result stalled");
`endif

endmodule

// ----- tb/tb_lattice_site_record_weigher_unit.sv -----
// Self-checking testbench for the lattice site record weigher: directed site and
// fault cases, then random block traffic, against a local model. Needs lsrw_pkg.
`timescale 1ns / 1ps

module tb_lattice_site_record_weigher_unit;
  import lsrw_pkg::*;

  localparam int MAX_EDGE = 16;
  localparam int SETTLE_CYCLES = 6;     // drain time after the last owed result
  localparam int STUCK_LIMIT = 2000;    // well above the long output stall below
  localparam int LONG_STALL = 300;
  localparam int ITEM_GOAL = 1900;      // items offered over the whole run

  // fault to plant in a simulated site
  localparam int FAULT_NONE = 0;
  localparam int FAULT_LINK = 1;
  localparam int FAULT_NORMAL = 2;

  // link kinds a simulated site may draw besides plain fluid links
  localparam logic [2:0] KIND_WALL = 3'b001;
  localparam logic [2:0] KIND_INLET = 3'b010;
  localparam logic [2:0] KIND_OUTLET = 3'b100;

  typedef struct packed {
    logic [31:0] weight;
    logic [1:0]  status;
  } weigh_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_W_FLUID;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;      // [31:0] data_word
  logic        s_tuser = 1'b0;    // [0] block_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [31:0] block_weight
  logic [1:0]  m_tuser;           // [1:0] status

  lattice_site_record_weigher_unit #(
    .MAX_EDGE(MAX_EDGE)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Local model of the parser. Register copies track every cfg write; parser
  // state follows each accepted item.
  // ---------------------------------------------------------------------------
  logic [31:0] weight_q [6] = '{default: WEIGHT_RESET};
  logic [4:0]  blk_edge_q = EDGE_RESET;

  logic [2:0]  wp_phase = PH_SITE_FLAG;
  int unsigned wp_links = 0;
  int unsigned wp_sites = 0;
  logic [2:0]  wp_class = CL_FLUID;
  logic [31:0] wp_sum = '0;
  bit          wp_hold = 1'b0;

  weigh_result_t pending_weights[$];   // block sums / error codes still owed

  int  words_sent = 0;       // items accepted by the block
  int  words_parsed = 0;     // items the parser actually consumed
  int  results_seen = 0;
  int  errors_seen = 0;
  int  mismatches = 0;
  int  stuck_cycles = 0;
  bit  quiet = 1'b0;         // both sides run gap-free while set
  int  hold_len = 0;         // one-shot long stall request for the sink

  function automatic int unsigned sites_in_block();
    int unsigned e;
    e = blk_edge_q;
    if (e < 1) e = 1;
    if (e > MAX_EDGE) e = MAX_EDGE;
    return e * e * e;
  endfunction

  function automatic bit flag_error(output weigh_result_t res, input logic [1:0] code);
    wp_hold = 1'b1;
    res.weight = '0;
    res.status = code;
    return 1'b1;
  endfunction

  function automatic bit close_site(output weigh_result_t res);
    wp_sites++;
    wp_phase = PH_SITE_FLAG;
    res.weight = wp_sum;
    res.status = ST_OK;
    if (wp_sites >= sites_in_block()) begin
      wp_phase = PH_DONE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit close_link(output weigh_result_t res);
    res = '0;
    wp_links++;
    if (wp_links < LINKS_PER_SITE) begin
      wp_phase = PH_LINK_TYPE;
      return 1'b0;
    end
    if (wp_class == CL_CONFLICT) return flag_error(res, ST_CONFLICT);
    case (wp_class)
      CL_FLUID:       wp_sum += weight_q[REG_W_FLUID];
      CL_WALL:        wp_sum += weight_q[REG_W_WALL];
      CL_INLET:       wp_sum += weight_q[REG_W_INLET];
      CL_OUTLET:      wp_sum += weight_q[REG_W_OUTLET];
      CL_INLET_WALL:  wp_sum += weight_q[REG_W_INLET_WALL];
      CL_OUTLET_WALL: wp_sum += weight_q[REG_W_OUTLET_WALL];
      default: ;
    endcase
    wp_phase = PH_NORMAL_FLAG;
    return 1'b0;
  endfunction

  // Steps the model by one accepted item; returns 1 when a result is owed.
  function automatic bit weigh_word(input logic [31:0] word, input logic start,
                                    output weigh_result_t res);
    res = '0;
    if (start) begin
      wp_phase = PH_SITE_FLAG;
      wp_links = 0;
      wp_sites = 0;
      wp_class = CL_FLUID;
      wp_sum = '0;
      wp_hold = 1'b0;
    end
    // error hold and a finished block swallow words until the next start
    if (wp_hold || wp_phase == PH_DONE) return 1'b0;
    words_parsed++;
    case (wp_phase)
      PH_SITE_FLAG: begin
        if (word != FLAG_SET) return close_site(res);   // solid site
        wp_class = CL_FLUID;
        wp_links = 0;
        wp_phase = PH_LINK_TYPE;
      end
      PH_LINK_TYPE: begin
        case (word)
          LT_FLUID: return close_link(res);
          LT_WALL: begin
            case (wp_class)
              CL_FLUID:  wp_class = CL_WALL;
              CL_INLET:  wp_class = CL_INLET_WALL;
              CL_OUTLET: wp_class = CL_OUTLET_WALL;
              default: ;
            endcase
            wp_phase = PH_PAY_LAST;
          end
          LT_INLET: begin
            case (wp_class)
              CL_FLUID:                      wp_class = CL_INLET;
              CL_WALL:                       wp_class = CL_INLET_WALL;
              CL_OUTLET, CL_OUTLET_WALL:     wp_class = CL_CONFLICT;
              default: ;
            endcase
            wp_phase = PH_PAY_CFG;
          end
          LT_OUTLET: begin
            case (wp_class)
              CL_FLUID:                      wp_class = CL_OUTLET;
              CL_WALL:                       wp_class = CL_OUTLET_WALL;
              CL_INLET, CL_INLET_WALL:       wp_class = CL_CONFLICT;
              default: ;
            endcase
            wp_phase = PH_PAY_CFG;
          end
          default: return flag_error(res, ST_BAD_LINK);
        endcase
      end
      PH_PAY_CFG:  wp_phase = PH_PAY_LAST;
      PH_PAY_LAST: return close_link(res);
      PH_NORMAL_FLAG: begin
        if (word == FLAG_CLEAR) return close_site(res);
        if (word != FLAG_SET) return flag_error(res, ST_BAD_NORMAL);
        wp_links = 0;
        wp_phase = PH_NORMAL;
      end
      PH_NORMAL: begin
        wp_links++;
        if (wp_links >= NORMAL_WORDS) return close_site(res);
      end
      default: wp_phase = PH_DONE;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side
  // ---------------------------------------------------------------------------

  // Offers one item after a random gap and waits for the handshake. valid is
  // left high on return so a gap-free next item keeps it up; idle_inputs()
  // drops it.
  task automatic send_word(input logic [31:0] word, input logic start);
    int gap;
    weigh_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= start;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    if (weigh_word(word, start, res)) pending_weights.push_back(res);
  endtask

  // Drops valid, waits out every owed result plus pipeline drain time.
  task automatic idle_inputs();
    s_tvalid <= 1'b0;
    while (pending_weights.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_BLOCK_EDGE) blk_edge_q = value[4:0];
    else if (idx <= REG_W_OUTLET_WALL) weight_q[idx] = value;
  endtask

  function automatic logic [31:0] solid_flag();
    logic [31:0] f;
    f = $urandom_range(0, 1) ? FLAG_CLEAR : $urandom;
    if (f == FLAG_SET) f = FLAG_CLEAR;
    return f;
  endfunction

  // One simulated site: flag, 26 link records with any payload, normal flag and
  // the optional normal. bad_word replaces a link type or the normal flag.
  task automatic send_sim_site(input logic start, input logic [2:0] kinds,
                               input int fault, input logic [31:0] bad_word);
    int bad_at;
    int pick;
    logic [31:0] lt;
    bad_at = (fault == FAULT_LINK) ? $urandom_range(0, LINKS_PER_SITE - 1) : -1;
    send_word(FLAG_SET, start);
    for (int i = 0; i < LINKS_PER_SITE; i++) begin
      pick = $urandom_range(0, 3);
      if (pick == 1 && (kinds & KIND_WALL) != 0) lt = LT_WALL;
      else if (pick == 2 && (kinds & KIND_INLET) != 0) lt = LT_INLET;
      else if (pick == 3 && (kinds & KIND_OUTLET) != 0) lt = LT_OUTLET;
      else lt = LT_FLUID;
      if (i == bad_at) lt = bad_word;
      send_word(lt, 1'b0);
      if (lt == LT_INLET || lt == LT_OUTLET) send_word($urandom, 1'b0);   // config
      if (lt == LT_WALL || lt == LT_INLET || lt == LT_OUTLET)
        send_word($urandom, 1'b0);                                          // distance
    end
    if (fault == FAULT_NORMAL) begin
      send_word(bad_word, 1'b0);
    end else if ($urandom_range(0, 1)) begin
      send_word(FLAG_SET, 1'b0);
      repeat (NORMAL_WORDS) send_word($urandom, 1'b0);
    end else begin
      send_word(FLAG_CLEAR, 1'b0);
    end
  endtask

  // A block sized to the current edge, sometimes one site short (cut by the
  // next start) or two long (tail ignored after the sum).
  task automatic send_random_block();
    int n_sites;
    int solid_pct;
    int roll;
    logic [2:0] kinds;
    n_sites = sites_in_block();
    case ($urandom_range(0, 7))
      0: if (n_sites > 1) n_sites--;
      1: n_sites += 2;
      default: ;
    endcase
    solid_pct = (n_sites > 10) ? 85 : 45;
    for (int s = 0; s < n_sites; s++) begin
      if ($urandom_range(0, 99) < solid_pct) begin
        send_word(solid_flag(), s == 0);
      end else begin
        kinds = 3'($urandom_range(0, 7));
        // most sites stay legal; a quarter of inlet+outlet draws keep the conflict
        if ((kinds & KIND_INLET) != 0 && (kinds & KIND_OUTLET) != 0 &&
            $urandom_range(0, 3) != 0)
          kinds &= $urandom_range(0, 1) ? ~KIND_INLET : ~KIND_OUTLET;
        roll = $urandom_range(0, 99);
        if (roll < 3)
          send_sim_site(s == 0, kinds, FAULT_LINK,
                        $urandom_range(0, 1) ? $urandom_range(4, 7) : ($urandom | 32'd4));
        else if (roll < 6)
          send_sim_site(s == 0, kinds, FAULT_NORMAL, $urandom | 32'd2);
        else
          send_sim_site(s == 0, kinds, FAULT_NONE, '0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls per item, plus the one-shot long stall
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_results
    weigh_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser != ST_OK) errors_seen++;
      if (pending_weights.size() == 0) begin
        report_mismatch($sformatf("unowed result weight %h status %0d", m_tdata, m_tuser));
      end else begin
        want = pending_weights.pop_front();
        if (m_tdata !== want.weight)
          report_mismatch($sformatf("weight %h, want %h", m_tdata, want.weight));
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
      end
    end
  end

  // Nothing moving on either side for too long means a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
        $display("FAIL lattice_site_record_weigher_unit");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Parser must run without a block start after reset, with reset weights;
  // lowering the edge to 0 (read as 1) mid-block ends the block on the next site.
  task automatic test_reset_defaults();
    send_sim_site(1'b0, '0, FAULT_NONE, '0);
    idle_inputs();
    write_reg(REG_BLOCK_EDGE, 32'd0);
    send_word(FLAG_CLEAR, 1'b0);
    send_word($urandom, 1'b0);          // block finished: ignored
    idle_inputs();
  endtask

  // One site of each class in an edge-2 block, weights at the extremes so the
  // sum wraps.
  task automatic test_class_weights();
    write_reg(REG_W_FLUID, 32'hFFFF_FFFF);
    write_reg(REG_W_WALL, 32'h0000_0000);
    write_reg(REG_W_INLET, $urandom);
    write_reg(REG_W_OUTLET, 32'h8000_0000);
    write_reg(REG_W_INLET_WALL, 32'h7FFF_FFFF);
    write_reg(REG_W_OUTLET_WALL, $urandom);
    write_reg(REG_BLOCK_EDGE, 32'd2);
    send_sim_site(1'b1, '0, FAULT_NONE, '0);
    send_sim_site(1'b0, KIND_WALL, FAULT_NONE, '0);
    send_sim_site(1'b0, KIND_INLET, FAULT_NONE, '0);
    send_sim_site(1'b0, KIND_OUTLET, FAULT_NONE, '0);
    send_sim_site(1'b0, KIND_INLET | KIND_WALL, FAULT_NONE, '0);
    send_sim_site(1'b0, KIND_OUTLET | KIND_WALL, FAULT_NONE, '0);
    send_word(FLAG_CLEAR, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    idle_inputs();
  endtask

  // Bad link types at both ends, conflict, bad normal flags, and a start that
  // cuts a block short.
  task automatic test_faults();
    write_reg(REG_BLOCK_EDGE, 32'd1);
    send_sim_site(1'b1, KIND_WALL, FAULT_LINK, 32'd4);
    send_word($urandom, 1'b0);          // held after the error
    send_sim_site(1'b1, KIND_INLET, FAULT_LINK, 32'hFFFF_FFFF);
    send_sim_site(1'b1, KIND_INLET | KIND_OUTLET, FAULT_NONE, '0);
    send_sim_site(1'b1, KIND_WALL, FAULT_NORMAL, 32'd2);
    send_sim_site(1'b1, KIND_OUTLET, FAULT_NORMAL, 32'hFFFF_FFFF);
    idle_inputs();
    write_reg(REG_BLOCK_EDGE, 32'd2);
    send_sim_site(1'b1, KIND_WALL, FAULT_NONE, '0);
    send_word(FLAG_CLEAR, 1'b0);
    send_word(FLAG_CLEAR, 1'b1);        // restart: earlier sites dropped
    repeat (7) send_word(solid_flag(), 1'b0);
    idle_inputs();
  endtask

  // Edges above the max clamp to 16; lowering the edge mid-block ends it once
  // the count has passed the new size.
  task automatic test_edge_range();
    write_reg(REG_BLOCK_EDGE, 32'd31);
    send_word(FLAG_CLEAR, 1'b1);
    repeat (39) send_word(solid_flag(), 1'b0);
    idle_inputs();
    write_reg(REG_BLOCK_EDGE, 32'd17);
    repeat (5) send_word(solid_flag(), 1'b0);
    idle_inputs();
    write_reg(REG_BLOCK_EDGE, 32'd3);
    send_word(solid_flag(), 1'b0);
    idle_inputs();
  endtask

  // Sink stalls for a long stretch while one-site blocks keep coming, so the
  // output and input registers fill and s_tready drops.
  task automatic test_backpressure();
    write_reg(REG_BLOCK_EDGE, 32'd1);
    quiet = 1'b1;
    hold_len = LONG_STALL;
    repeat (40) send_word(solid_flag(), 1'b1);
    quiet = 1'b0;
    idle_inputs();
  endtask

  // Phases of random blocks, each under fresh weights and edge, until the
  // item budget of the run is spent.
  task automatic test_random_traffic();
    int pick;
    logic [31:0] w;
    while (words_sent < ITEM_GOAL) begin
      idle_inputs();
      quiet = ($urandom_range(0, 3) == 0);
      for (int r = REG_W_FLUID; r <= REG_W_OUTLET_WALL; r++) begin
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 3))
            0: w = 32'h0000_0000;
            1: w = 32'hFFFF_FFFF;
            2: w = $urandom_range(0, 15);
            default: w = $urandom;
          endcase
          write_reg(3'(r), w);
        end
      end
      pick = $urandom_range(0, 9);
      write_reg(REG_BLOCK_EDGE, (pick < 2) ? 32'd0 : (pick < 6) ? 32'd1 :
                                (pick < 9) ? 32'd2 : 32'd3);
      repeat ($urandom_range(2, 5)) begin
        if (words_sent < ITEM_GOAL) send_random_block();
      end
    end
    quiet = 1'b0;
    idle_inputs();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_class_weights();
    test_faults();
    test_edge_range();
    test_backpressure();
    test_random_traffic();
    idle_inputs();
    repeat (20) @(posedge clk);
    $display("run: %0d words sent, %0d parsed, %0d results checked (%0d error codes)",
             words_sent, words_parsed, results_seen, errors_seen);
    $display("run: all site classes and faults, edges 0..31, weights 0/all-ones, %0d-cycle stall",
             LONG_STALL);
    if (mismatches == 0) begin
      $display("PASS lattice_site_record_weigher_unit");
    end else begin
      $display("FAIL lattice_site_record_weigher_unit");
    end
    $finish;
  end

endmodule
